// ===== hdl/quaternion_to_zyx_euler_top_assert.svh =====
// Assertion macros for the quaternion to ZYX Euler angle block
`ifndef QUATERNION_TO_ZYX_EULER_TOP_ASSERT_SVH
`define QUATERNION_TO_ZYX_EULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define Q2E_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("q2e assertion failed");
`define Q2E_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("q2e assertion failed");
`else
`define Q2E_ASSERT(lbl, clk, rst_n, prop)
`define Q2E_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== hdl/q2e_pkg.sv =====
// Package: constants, widths and arctangent table for the Euler angle pipeline
package q2e_pkg;
  localparam int CORDIC_STAGES = 16;
  localparam int SQRT_ITERS    = 32;
  localparam int SQRT_STAGES   = SQRT_ITERS / 2;
  localparam int CW            = 36;
  localparam int ZW            = 34;
  localparam int LAT           = 5 + SQRT_STAGES + CORDIC_STAGES + 1;
  localparam int DLY           = 2 + SQRT_STAGES;

  function automatic logic [31:0] atan_val(input int idx);
    logic [31:0] v;
    case (idx)
      0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
      3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
     12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
     15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
     18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
     21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
     24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
     27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
     30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction
endpackage

// ===== hdl/q2e_if.sv =====
// Stream interfaces: quaternion input beats and Euler angle output beats
interface q2e_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface q2e_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] roll_angle;
  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

// ===== hdl/q2e_isqrt.sv =====
// Pipelined integer square root, two result bits per stage
module q2e_isqrt
  import q2e_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] v_i,
  output logic [31:0] root_o
);
  logic [63:0] rem_q [SQRT_STAGES];
  logic [63:0] res_q [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stg
    logic [63:0] rem_in, res_in, rem_d, res_d, b;
    if (s == 0) begin : g_first
      assign rem_in = v_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign res_in = res_q[s-1];
    end
    always_comb begin
      rem_d = rem_in;
      res_d = res_in;
      b     = '0;
      for (int j = 0; j < 2; j++) begin
        b = 64'd1 << (62 - 4 * s - 2 * j);
        if (rem_d >= res_d + b) begin
          rem_d = rem_d - (res_d + b);
          res_d = (res_d >> 1) + b;
        end else begin
          res_d = res_d >> 1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        res_q[s] <= res_d;
      end
    end
  end

  assign root_o = res_q[SQRT_STAGES-1][31:0];
endmodule

// ===== hdl/q2e_cordic.sv =====
// Pipelined vectoring CORDIC atan2, one rotation per stage
module q2e_cordic
  import q2e_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] x_i,
  output logic signed [ZW-1:0] z_o
);
  logic signed [CW-1:0] x_q [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_q [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_q [CORDIC_STAGES+1];
  logic                 zr_q [CORDIC_STAGES+1];
  logic signed [CW-1:0] x0_d, y0_d;
  logic signed [ZW-1:0] z0_d;

  always_comb begin
    x0_d = x_i;
    y0_d = y_i;
    z0_d = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0_d = y_i;
        y0_d = -x_i;
        z0_d = ZW'(64'sd1073741824);
      end else begin
        x0_d = -y_i;
        y0_d = x_i;
        z0_d = -ZW'(64'sd1073741824);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= x0_d;
      y_q[0]  <= y0_d;
      z_q[0]  <= z0_d;
      zr_q[0] <= (x_i == 0) && (y_i == 0);
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stg
    localparam logic signed [ZW-1:0] ANG = ZW'(atan_val(k));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zr_q[k+1] <= zr_q[k];
        if (y_q[k] >= 0) begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + ANG;
        end else begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - ANG;
        end
      end
    end
  end

  assign z_o = zr_q[CORDIC_STAGES] ? '0 : z_q[CORDIC_STAGES];
endmodule

// ===== hdl/quaternion_to_zyx_euler_top.sv =====
// Throughput: one beat per cycle; every stage advances whenever the output
// register is empty or taken, so a stall freezes the whole pipeline.
// Depth is set by the 16-stage square root and the CORDIC stage chain.
// Reset: asynchronous active low, clears the valid bits only.
module quaternion_to_zyx_euler_top
  import q2e_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  q2e_in_if.sink        in_i,
  q2e_out_if.source     out_o
);
  `include "quaternion_to_zyx_euler_top_assert.svh"

  logic en;
  logic [LAT-1:0] vld_q;

  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, zw_q, xz_q, yw_q, yz_q, xw_q;
  logic signed [31:0] r00_q, r10_q, r20_q, r21_q, r22_q;
  logic signed [63:0] s21_q, s22_q;
  logic [63:0] sum_q;
  logic signed [31:0] d00_q [DLY], d10_q [DLY], d20_q [DLY], d21_q [DLY], d22_q [DLY];
  logic [31:0] root;
  logic signed [ZW-1:0] zy, zp, zr;
  logic signed [ZW-1:0] ry, rp, rr;
  logic signed [15:0] yaw_q, pitch_q, roll_q, pitch_d;

  function automatic logic signed [31:0] sat_t(input logic signed [35:0] v);
    if (v > 36'sd1073741824) return 32'sd1073741824;
    if (v < -36'sd1073741824) return -32'sd1073741824;
    return v[31:0];
  endfunction

  assign en         = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q  <= 32'(in_i.quat_x) * 32'(in_i.quat_x);
      yy_q  <= 32'(in_i.quat_y) * 32'(in_i.quat_y);
      zz_q  <= 32'(in_i.quat_z) * 32'(in_i.quat_z);
      xy_q  <= 32'(in_i.quat_x) * 32'(in_i.quat_y);
      zw_q  <= 32'(in_i.quat_z) * 32'(in_i.quat_w);
      xz_q  <= 32'(in_i.quat_x) * 32'(in_i.quat_z);
      yw_q  <= 32'(in_i.quat_y) * 32'(in_i.quat_w);
      yz_q  <= 32'(in_i.quat_y) * 32'(in_i.quat_z);
      xw_q  <= 32'(in_i.quat_x) * 32'(in_i.quat_w);
      r00_q <= sat_t(36'sd1073741824 - ((36'(yy_q) + 36'(zz_q)) <<< 1));
      r10_q <= sat_t((36'(xy_q) + 36'(zw_q)) <<< 1);
      r20_q <= sat_t((36'(xz_q) - 36'(yw_q)) <<< 1);
      r21_q <= sat_t((36'(yz_q) + 36'(xw_q)) <<< 1);
      r22_q <= sat_t(36'sd1073741824 - ((36'(xx_q) + 36'(yy_q)) <<< 1));
      s21_q <= 64'(r21_q) * 64'(r21_q);
      s22_q <= 64'(r22_q) * 64'(r22_q);
      sum_q <= 64'(s21_q) + 64'(s22_q);
      d00_q[0] <= r00_q;
      d10_q[0] <= r10_q;
      d20_q[0] <= r20_q;
      d21_q[0] <= r21_q;
      d22_q[0] <= r22_q;
      for (int i = 1; i < DLY; i++) begin
        d00_q[i] <= d00_q[i-1];
        d10_q[i] <= d10_q[i-1];
        d20_q[i] <= d20_q[i-1];
        d21_q[i] <= d21_q[i-1];
        d22_q[i] <= d22_q[i-1];
      end
    end
  end

  q2e_isqrt u_isqrt (.clk_i, .en_i(en), .v_i(sum_q), .root_o(root));

  q2e_cordic u_yaw (
    .clk_i, .en_i(en),
    .y_i(CW'(d10_q[DLY-1])), .x_i(CW'(d00_q[DLY-1])), .z_o(zy)
  );
  q2e_cordic u_pitch (
    .clk_i, .en_i(en),
    .y_i(-CW'(d20_q[DLY-1])), .x_i(CW'({1'b0, root})), .z_o(zp)
  );
  q2e_cordic u_roll (
    .clk_i, .en_i(en),
    .y_i(CW'(d21_q[DLY-1])), .x_i(CW'(d22_q[DLY-1])), .z_o(zr)
  );

  assign ry = (zy + ZW'(32768)) >>> 16;
  assign rp = (zp + ZW'(32768)) >>> 16;
  assign rr = (zr + ZW'(32768)) >>> 16;

  always_comb begin
    if (rp > ZW'(16384)) pitch_d = 16'sd16384;
    else if (rp < -ZW'(16384)) pitch_d = -16'sd16384;
    else pitch_d = rp[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_q   <= ry[15:0];
      pitch_q <= pitch_d;
      roll_q  <= rr[15:0];
    end
  end

  assign out_o.valid       = vld_q[LAT-1];
  assign out_o.yaw_angle   = yaw_q;
  assign out_o.pitch_angle = pitch_q;
  assign out_o.roll_angle  = roll_q;

  `Q2E_ASSERT_NEXT(a_enter, clk_i, rst_ni, in_i.valid && in_i.ready, vld_q[0])
  `Q2E_ASSERT_NEXT(a_hold, clk_i, rst_ni, !en, $stable(vld_q))
  `Q2E_ASSERT(a_pitch, clk_i, rst_ni, out_o.valid |-> (pitch_q <= 16'sd16384 && pitch_q >= -16'sd16384))
endmodule
